// ===== sv/sequence_reorder_buffer_macros.svh =====
// Assertion helpers shared by the reorder buffer RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SEQUENCE_REORDER_BUFFER_MACROS_SVH
`define SEQUENCE_REORDER_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reorder buffer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reorder buffer: next-cycle check failed");

`endif

// ===== sv/srb_pkg.sv =====
`default_nettype none

package srb_pkg;

  localparam int ID_BITS        = 32;
  localparam int PAYLOAD_BITS   = 32;
  localparam int CMD_BITS       = 3;
  localparam int STATUS_BITS    = 3;
  localparam int WINDOW_DEFAULT = 64;

  localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_MARK   = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_POP    = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_STOP   = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_DELIVERED = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_READY = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_STOPPED   = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_STALE     = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_AHEAD     = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd6;

  typedef struct packed {
    logic present;
    logic dropped;
  } slot_state_t;

  typedef enum logic {
    OP_LOCATE,
    OP_STEP
  } unit_op_t;

endpackage

`default_nettype wire

// ===== sv/srb_if.sv =====
`default_nettype none

interface srb_in_if;
  logic                              valid;
  logic                              ready;
  logic [srb_pkg::CMD_BITS-1:0]      cmd;
  logic [srb_pkg::ID_BITS-1:0]       seq_id;
  logic [srb_pkg::PAYLOAD_BITS-1:0]  payload;

  modport source (output valid, output cmd, output seq_id, output payload, input ready);
  modport sink (input valid, input cmd, input seq_id, input payload, output ready);
endinterface

interface srb_out_if;
  logic                              valid;
  logic                              ready;
  logic [srb_pkg::STATUS_BITS-1:0]   status;
  logic [srb_pkg::ID_BITS-1:0]       out_frame_id;
  logic [srb_pkg::PAYLOAD_BITS-1:0]  out_payload;
  logic [srb_pkg::ID_BITS-1:0]       next_expected;

  modport source (output valid, output status, output out_frame_id, output out_payload,
                  output next_expected, input ready);
  modport sink (input valid, input status, input out_frame_id, input out_payload,
                input next_expected, output ready);
endinterface

`default_nettype wire

// ===== sv/srb_unit.sv =====
`default_nettype none

// Shared id/slot arithmetic. In locate mode it forms the distance of an id
// from the head and the slot that id maps to; in step mode it advances the head.
module srb_unit #(
  parameter int WINDOW = srb_pkg::WINDOW_DEFAULT,
  parameter int SLOT_W = $clog2(WINDOW)
) (
  input  var srb_pkg::unit_op_t           op,
  input  wire [srb_pkg::ID_BITS-1:0]      seq_id,
  input  wire [srb_pkg::ID_BITS-1:0]      head_id,
  input  wire [SLOT_W-1:0]                head_slot,
  output logic [srb_pkg::ID_BITS-1:0]     sum_id,
  output logic [SLOT_W-1:0]               slot,
  output logic                            in_window,
  output logic                            stale
);

  logic [srb_pkg::ID_BITS-1:0] id_a;
  logic [srb_pkg::ID_BITS-1:0] id_b;
  logic [SLOT_W-1:0]           slot_off;
  logic [SLOT_W:0]             slot_sum;

  always_comb begin
    if (op == srb_pkg::OP_LOCATE) begin
      id_a = seq_id;
      id_b = ~head_id;
    end else begin
      id_a = head_id;
      id_b = '0;
    end
    sum_id    = id_a + id_b + srb_pkg::ID_BITS'(1);
    in_window = sum_id < srb_pkg::ID_BITS'(WINDOW);
    stale     = sum_id[srb_pkg::ID_BITS-1];

    slot_off = (op == srb_pkg::OP_LOCATE) ? sum_id[SLOT_W-1:0] : SLOT_W'(1);
    slot_sum = {1'b0, head_slot} + {1'b0, slot_off};
    // Both operands stay below WINDOW, so one subtract wraps the sum.
    if (slot_sum >= (SLOT_W+1)'(WINDOW)) begin
      slot = SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW));
    end else begin
      slot = slot_sum[SLOT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/srb_store.sv =====
`default_nettype none

// Slot storage: per-slot present/dropped flags and payloads.
// One write and one read address per cycle, read data registered.
module srb_store #(
  parameter int WINDOW = srb_pkg::WINDOW_DEFAULT,
  parameter int SLOT_W = $clog2(WINDOW)
) (
  input  wire                                 clk,
  input  wire                                 st_we,
  input  wire [SLOT_W-1:0]                    waddr,
  input  var srb_pkg::slot_state_t            wstate,
  input  wire                                 pay_we,
  input  wire [srb_pkg::PAYLOAD_BITS-1:0]     wpay,
  input  wire [SLOT_W-1:0]                    raddr,
  output srb_pkg::slot_state_t                rd_state,
  output logic [srb_pkg::PAYLOAD_BITS-1:0]    rd_pay
);

  srb_pkg::slot_state_t              state_mem [WINDOW];
  logic [srb_pkg::PAYLOAD_BITS-1:0]  pay_mem [WINDOW];
  srb_pkg::slot_state_t              rd_state_r;
  logic [srb_pkg::PAYLOAD_BITS-1:0]  rd_pay_r;

  always_ff @(posedge clk) begin
    if (st_we) begin
      state_mem[waddr] <= wstate;
    end
    rd_state_r <= state_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[waddr] <= wpay;
    end
    rd_pay_r <= pay_mem[raddr];
  end

  assign rd_state = rd_state_r;
  assign rd_pay   = rd_pay_r;

endmodule

`default_nettype wire

// ===== sv/srb_ctrl.sv =====
`default_nettype none

`include "sequence_reorder_buffer_macros.svh"

module srb_ctrl #(
  parameter int WINDOW = srb_pkg::WINDOW_DEFAULT,
  parameter int SLOT_W = $clog2(WINDOW)
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  srb_in_if.sink                              in_ch,
  srb_out_if.source                           out_ch,
  output srb_pkg::unit_op_t                   unit_op,
  output logic [srb_pkg::ID_BITS-1:0]         unit_seq_id,
  output logic [srb_pkg::ID_BITS-1:0]         unit_head_id,
  output logic [SLOT_W-1:0]                   unit_head_slot,
  input  wire [srb_pkg::ID_BITS-1:0]          u_sum_id,
  input  wire [SLOT_W-1:0]                    u_slot,
  input  wire                                 u_in_window,
  input  wire                                 u_stale,
  output logic                                st_we,
  output logic [SLOT_W-1:0]                   waddr,
  output srb_pkg::slot_state_t                wstate,
  output logic                                pay_we,
  output logic [srb_pkg::PAYLOAD_BITS-1:0]    wpay,
  output logic [SLOT_W-1:0]                   raddr,
  input  var srb_pkg::slot_state_t            rd_state,
  input  wire [srb_pkg::PAYLOAD_BITS-1:0]     rd_pay
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_HEAD,
    S_WALK,
    S_CLEAR,
    S_EMIT
  } state_t;

  state_t                             state_r, state_nxt;
  logic                               boot_r, boot_nxt;
  logic                               halted_r, halted_nxt;
  logic [srb_pkg::ID_BITS-1:0]        head_id_r, head_id_nxt;
  logic [SLOT_W-1:0]                  head_slot_r, head_slot_nxt;
  logic [SLOT_W-1:0]                  clr_idx_r, clr_idx_nxt;
  logic [SLOT_W-1:0]                  slot_r, slot_nxt;
  logic [srb_pkg::CMD_BITS-1:0]       cmd_r, cmd_nxt;
  logic [srb_pkg::ID_BITS-1:0]        id_r, id_nxt;
  logic [srb_pkg::PAYLOAD_BITS-1:0]   pay_r, pay_nxt;
  logic [srb_pkg::STATUS_BITS-1:0]    res_status_r, res_status_nxt;
  logic [srb_pkg::ID_BITS-1:0]        res_id_r, res_id_nxt;
  logic [srb_pkg::PAYLOAD_BITS-1:0]   res_pay_r, res_pay_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [srb_pkg::STATUS_BITS-1:0]    out_status_r, out_status_nxt;
  logic [srb_pkg::ID_BITS-1:0]        out_id_r, out_id_nxt;
  logic [srb_pkg::PAYLOAD_BITS-1:0]   out_pay_r, out_pay_nxt;
  logic [srb_pkg::ID_BITS-1:0]        out_next_r, out_next_nxt;
  logic                               out_not_delivered;
  logic                               out_fields_zero;
  logic                               walk_on_drop;
  logic                               walk_clears_head;

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.out_frame_id  = out_id_r;
  assign out_ch.out_payload   = out_pay_r;
  assign out_ch.next_expected = out_next_r;

  assign unit_seq_id    = id_r;
  assign unit_head_id   = head_id_r;
  assign unit_head_slot = head_slot_r;
  assign wpay           = pay_r;

  always_comb begin
    state_nxt      = state_r;
    boot_nxt       = boot_r;
    halted_nxt     = halted_r;
    head_id_nxt    = head_id_r;
    head_slot_nxt  = head_slot_r;
    clr_idx_nxt    = clr_idx_r;
    slot_nxt       = slot_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    pay_nxt        = pay_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_pay_nxt    = out_pay_r;
    out_next_nxt   = out_next_r;

    unit_op = srb_pkg::OP_LOCATE;
    st_we   = 1'b0;
    pay_we  = 1'b0;
    waddr   = head_slot_r;
    wstate  = '0;
    raddr   = head_slot_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          id_nxt    = in_ch.seq_id;
          pay_nxt   = in_ch.payload;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_nxt = srb_pkg::ST_ACCEPTED;
        res_id_nxt     = '0;
        res_pay_nxt    = '0;
        case (cmd_r)
          srb_pkg::CMD_INSERT, srb_pkg::CMD_MARK: begin
            if (u_in_window) begin
              slot_nxt  = u_slot;
              raddr     = u_slot;
              state_nxt = S_CHECK;
            end else begin
              res_status_nxt = u_stale ? srb_pkg::ST_STALE : srb_pkg::ST_AHEAD;
              state_nxt      = S_EMIT;
            end
          end
          srb_pkg::CMD_POP: begin
            if (halted_r) begin
              res_status_nxt = srb_pkg::ST_STOPPED;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_HEAD;
            end
          end
          srb_pkg::CMD_CLEAR: begin
            head_id_nxt   = '0;
            head_slot_nxt = '0;
            clr_idx_nxt   = '0;
            state_nxt     = S_CLEAR;
          end
          srb_pkg::CMD_STOP: begin
            halted_nxt = 1'b1;
            state_nxt  = S_EMIT;
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end

      S_CHECK: begin
        waddr = slot_r;
        if (cmd_r == srb_pkg::CMD_INSERT) begin
          if (rd_state.present || rd_state.dropped) begin
            res_status_nxt = srb_pkg::ST_DUPLICATE;
          end else begin
            st_we          = 1'b1;
            wstate.present = 1'b1;
            pay_we         = 1'b1;
          end
          state_nxt = S_EMIT;
        end else begin
          if (rd_state.dropped) begin
            res_status_nxt = srb_pkg::ST_DUPLICATE;
            state_nxt      = S_EMIT;
          end else begin
            // Marking frees any stored item; then the head walk runs.
            st_we          = 1'b1;
            wstate.dropped = 1'b1;
            state_nxt      = S_HEAD;
          end
        end
      end

      S_HEAD: begin
        raddr     = head_slot_r;
        state_nxt = S_WALK;
      end

      S_WALK: begin
        // The read data holds the head slot. The next slot is fetched
        // in the same cycle, so the walk needs no separate read per skipped slot.
        unit_op = srb_pkg::OP_STEP;
        waddr   = head_slot_r;
        raddr   = u_slot;
        if (rd_state.dropped) begin
          st_we         = 1'b1;
          head_id_nxt   = u_sum_id;
          head_slot_nxt = u_slot;
        end else if (cmd_r == srb_pkg::CMD_POP) begin
          if (rd_state.present) begin
            st_we          = 1'b1;
            res_status_nxt = srb_pkg::ST_DELIVERED;
            res_id_nxt     = head_id_r;
            res_pay_nxt    = rd_pay;
            head_id_nxt    = u_sum_id;
            head_slot_nxt  = u_slot;
          end else begin
            res_status_nxt = srb_pkg::ST_NOT_READY;
          end
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_CLEAR: begin
        st_we = 1'b1;
        waddr = clr_idx_r;
        if (clr_idx_r == SLOT_W'(WINDOW - 1)) begin
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? S_IDLE : S_EMIT;
        end else begin
          clr_idx_nxt = clr_idx_r + SLOT_W'(1);
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_pay_nxt    = res_pay_r;
          out_next_nxt   = head_id_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      boot_r      <= 1'b1;
      halted_r    <= 1'b0;
      head_id_r   <= '0;
      head_slot_r <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      halted_r    <= halted_nxt;
      head_id_r   <= head_id_nxt;
      head_slot_r <= head_slot_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r       <= slot_nxt;
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    pay_r        <= pay_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_pay_r    <= out_pay_nxt;
    out_next_r   <= out_next_nxt;
  end

  assign out_not_delivered = out_valid_r && (out_status_r != srb_pkg::ST_DELIVERED);
  assign out_fields_zero   = (out_id_r == '0) && (out_pay_r == '0);
  assign walk_on_drop      = (state_r == S_WALK) && rd_state.dropped;
  assign walk_clears_head  = st_we && (waddr == head_slot_r) && (wstate == '0);

  `SRB_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `SRB_ASSERT_SAME(a_zero_unless_delivered, out_not_delivered, out_fields_zero)
  `SRB_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r)
  `SRB_ASSERT_SAME(a_walk_frees_head, walk_on_drop, walk_clears_head)

endmodule

`default_nettype wire

// ===== sv/sequence_reorder_buffer.sv =====
// Sequence reorder buffer. Commands arrive on in_ch (cmd, seq_id, payload):
// insert, mark dropped, pop, clear and stop. Every command yields exactly one
// transaction on out_ch with status, the delivered id and payload (zero unless
// delivered) and the head id after the command.
// Commands run one at a time on a small sequencer that shares one id/slot
// adder and one slot memory port. From acceptance to the output register,
// insert and duplicate mark pass decode, check and emit; stop, unknown codes,
// out-of-window ids and pop while stopped pass decode and emit; pop passes
// decode, head, walk and emit, and mark dropped passes decode, check, head,
// walk and emit. The walk skips the dropped slots at the head, one per cycle,
// at most WINDOW of them. Clear sweeps the slot flags, one slot a cycle.
// in_ch.ready returns high together with out_ch.valid, so the next command
// is not taken before the result of the last one is loaded.
// After reset the block sweeps all WINDOW slot flags with in_ch.ready low,
// then waits for commands; the head id is zero and the stop flag is clear. A
// result held in the output register while out_ch is stalled does not block
// the next command; only the following result waits for it.
`default_nettype none

module sequence_reorder_buffer #(
  parameter int WINDOW = srb_pkg::WINDOW_DEFAULT
) (
  input  wire        clk,
  input  wire        rst_n,
  srb_in_if.sink     in_ch,
  srb_out_if.source  out_ch
);

  localparam int SLOT_W = $clog2(WINDOW);

  srb_pkg::unit_op_t                  unit_op;
  logic [srb_pkg::ID_BITS-1:0]        unit_seq_id;
  logic [srb_pkg::ID_BITS-1:0]        unit_head_id;
  logic [SLOT_W-1:0]                  unit_head_slot;
  logic [srb_pkg::ID_BITS-1:0]        u_sum_id;
  logic [SLOT_W-1:0]                  u_slot;
  logic                               u_in_window;
  logic                               u_stale;
  logic                               st_we;
  logic [SLOT_W-1:0]                  waddr;
  srb_pkg::slot_state_t               wstate;
  logic                               pay_we;
  logic [srb_pkg::PAYLOAD_BITS-1:0]   wpay;
  logic [SLOT_W-1:0]                  raddr;
  srb_pkg::slot_state_t               rd_state;
  logic [srb_pkg::PAYLOAD_BITS-1:0]   rd_pay;

  srb_unit #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W)
  ) u_unit (
    .op        (unit_op),
    .seq_id    (unit_seq_id),
    .head_id   (unit_head_id),
    .head_slot (unit_head_slot),
    .sum_id    (u_sum_id),
    .slot      (u_slot),
    .in_window (u_in_window),
    .stale     (u_stale)
  );

  srb_store #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W)
  ) u_store (
    .clk      (clk),
    .st_we    (st_we),
    .waddr    (waddr),
    .wstate   (wstate),
    .pay_we   (pay_we),
    .wpay     (wpay),
    .raddr    (raddr),
    .rd_state (rd_state),
    .rd_pay   (rd_pay)
  );

  srb_ctrl #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .unit_op        (unit_op),
    .unit_seq_id    (unit_seq_id),
    .unit_head_id   (unit_head_id),
    .unit_head_slot (unit_head_slot),
    .u_sum_id       (u_sum_id),
    .u_slot         (u_slot),
    .u_in_window    (u_in_window),
    .u_stale        (u_stale),
    .st_we          (st_we),
    .waddr          (waddr),
    .wstate         (wstate),
    .pay_we         (pay_we),
    .wpay           (wpay),
    .raddr          (raddr),
    .rd_state       (rd_state),
    .rd_pay         (rd_pay)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN        = srb_pkg::WINDOW_DEFAULT;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned MAX_NOTED  = 10;
  localparam int          CMD_W      = srb_pkg::CMD_BITS;
  localparam int          ST_W       = srb_pkg::STATUS_BITS;
  localparam int          ID_W       = srb_pkg::ID_BITS;
  localparam int          PAY_W      = srb_pkg::PAYLOAD_BITS;

  // Command codes the block does not define. They must be answered as accepted.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  seq;
    logic [PAY_W-1:0] payload;
    logic [ID_W-1:0]  head;
  } srb_result_t;

  class reorder_scoreboard;
    logic [PAY_W-1:0]        stored_payload [WIN];
    bit                      held [WIN];
    bit                      dropped [WIN];
    logic [ID_W-1:0]         head_id;
    int unsigned             head_slot;
    bit                      halted;
    srb_result_t             pending_results [$];
    int unsigned             failures;
    int unsigned             commands;
    int unsigned             status_seen [8];

    function new();
      foreach (held[i]) begin
        held[i] = 1'b0;
        dropped[i] = 1'b0;
        stored_payload[i] = '0;
      end
      head_id = '0;
      head_slot = 0;
      halted = 1'b0;
      failures = 0;
      commands = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void step_head();
      head_id = head_id + 1'b1;
      head_slot = (head_slot + 1) % WIN;
    endfunction

    // Walk the head over dropped ids, at most one full window.
    function void skip_dropped_head();
      for (int unsigned n = 0; n < WIN; n++) begin
        if (!dropped[head_slot]) break;
        dropped[head_slot] = 1'b0;
        held[head_slot] = 1'b0;
        step_head();
      end
    endfunction

    // Serial-number window test: in window, behind the head, or too far ahead.
    function logic [ST_W-1:0] locate(input logic [ID_W-1:0] id,
                                     output int unsigned slot);
      logic [ID_W-1:0] offs;
      offs = id - head_id;
      slot = 0;
      if (offs < WIN) begin
        slot = (head_slot + offs) % WIN;
        return srb_pkg::ST_ACCEPTED;
      end
      return offs[ID_W-1] ? srb_pkg::ST_STALE : srb_pkg::ST_AHEAD;
    endfunction

    function void note_command(input logic [CMD_W-1:0] cmd,
                               input logic [ID_W-1:0] id,
                               input logic [PAY_W-1:0] pay);
      srb_result_t r;
      int unsigned slot;
      r.status = srb_pkg::ST_ACCEPTED;
      r.seq = '0;
      r.payload = '0;
      case (cmd)
        srb_pkg::CMD_INSERT: begin
          r.status = locate(id, slot);
          if (r.status == srb_pkg::ST_ACCEPTED) begin
            if (held[slot] || dropped[slot]) begin
              r.status = srb_pkg::ST_DUPLICATE;
            end else begin
              stored_payload[slot] = pay;
              held[slot] = 1'b1;
            end
          end
        end
        srb_pkg::CMD_MARK: begin
          r.status = locate(id, slot);
          if (r.status == srb_pkg::ST_ACCEPTED) begin
            if (dropped[slot]) begin
              r.status = srb_pkg::ST_DUPLICATE;
            end else begin
              held[slot] = 1'b0;
              dropped[slot] = 1'b1;
              skip_dropped_head();
            end
          end
        end
        srb_pkg::CMD_POP: begin
          if (halted) begin
            r.status = srb_pkg::ST_STOPPED;
          end else begin
            skip_dropped_head();
            if (held[head_slot]) begin
              r.status = srb_pkg::ST_DELIVERED;
              r.seq = head_id;
              r.payload = stored_payload[head_slot];
              held[head_slot] = 1'b0;
              step_head();
            end else begin
              r.status = srb_pkg::ST_NOT_READY;
            end
          end
        end
        srb_pkg::CMD_CLEAR: begin
          foreach (held[i]) begin
            held[i] = 1'b0;
            dropped[i] = 1'b0;
          end
          head_id = '0;
          head_slot = 0;
        end
        srb_pkg::CMD_STOP: begin
          halted = 1'b1;
        end
        default: ;
      endcase
      r.head = head_id;
      commands++;
      status_seen[r.status]++;
      pending_results = {pending_results, r};
    endfunction

    function void check_result(input logic [ST_W-1:0] status,
                               input logic [ID_W-1:0] fid,
                               input logic [PAY_W-1:0] pay,
                               input logic [ID_W-1:0] head);
      srb_result_t e;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_NOTED)
          $display("%0t: result with no command outstanding: status %0d id %h payload %h head %h",
                   $realtime, status, fid, pay, head);
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status || fid !== e.seq || pay !== e.payload || head !== e.head) begin
        failures++;
        if (failures <= MAX_NOTED) begin
          $display("%0t: mismatch, expected status %0d id %h payload %h head %h",
                   $realtime, e.status, e.seq, e.payload, e.head);
          $display("%0t:           actual status %0d id %h payload %h head %h",
                   $realtime, status, fid, pay, head);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  srb_in_if  in_ch ();
  srb_out_if out_ch ();

  sequence_reorder_buffer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  reorder_scoreboard sb = new();

  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned rx_cycle;
  int unsigned rx_mode;
  int unsigned drains;

  always begin
    #4;
    clk = 1'b1;
    #4;
    clk = 1'b0;
  end

  // Receiver: switches at random between several stall patterns.
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 150 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(0, 3) != 0);
      2: out_ch.ready = ((rx_cycle % 5) < 2);
      default: out_ch.ready = ($urandom_range(0, 11) == 0);
    endcase
  end

  // Monitor and watchdog. Inputs are noted before results are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_command(in_ch.cmd, in_ch.seq_id, in_ch.payload);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.out_frame_id, out_ch.out_payload,
                        out_ch.next_expected);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, sb.pending_results.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic issue(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                       input logic [PAY_W-1:0] pay);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.cmd = c;
    in_ch.seq_id = id;
    in_ch.payload = pay;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    burst_left--;
  endtask

  // Hold the sender off until every outstanding result has been returned.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    burst_left = 0;
    drains++;
  endtask

  function automatic logic [ID_W-1:0] id_near_head();
    int unsigned offs;
    offs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, WIN - 1);
    return sb.head_id + offs;
  endfunction

  task automatic run_directed();
    issue(srb_pkg::CMD_POP, 32'd0, 32'd0);
    issue(srb_pkg::CMD_INSERT, 32'd0, 32'hFFFF_FFFF);
    issue(srb_pkg::CMD_INSERT, 32'd0, 32'h1234_5678);
    issue(srb_pkg::CMD_INSERT, WIN - 1, 32'd0);
    issue(srb_pkg::CMD_INSERT, WIN, 32'h0BAD_0BAD);
    issue(srb_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h1111_1111);
    issue(srb_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h2222_2222);
    issue(srb_pkg::CMD_INSERT, 32'h8000_0000, 32'h3333_3333);
    issue(srb_pkg::CMD_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(srb_pkg::CMD_INSERT, 32'd0, 32'h4444_4444);
    issue(srb_pkg::CMD_MARK, 32'd1, 32'd0);
    issue(srb_pkg::CMD_MARK, 32'd3, 32'd0);
    issue(srb_pkg::CMD_MARK, 32'd3, 32'd0);
    issue(srb_pkg::CMD_INSERT, 32'd3, 32'h5555_5555);
    issue(srb_pkg::CMD_INSERT, 32'd2, 32'hA5A5_A5A5);
    // Marking the head frees its stored item and skips the run of drops behind it.
    issue(srb_pkg::CMD_MARK, 32'd2, 32'd0);
    issue(srb_pkg::CMD_POP, 32'd0, 32'd0);
    issue(srb_pkg::CMD_INSERT, 32'd5, 32'h5A5A_5A5A);
    issue(srb_pkg::CMD_MARK, 32'd4, 32'd0);
    issue(srb_pkg::CMD_POP, 32'd0, 32'd0);
    issue(srb_pkg::CMD_MARK, WIN - 1, 32'd0);
    issue(srb_pkg::CMD_MARK, 32'd6 + WIN, 32'd0);
    issue(CMD_SPARE_A, $urandom, $urandom);
    issue(CMD_SPARE_B, $urandom, $urandom);
    issue(CMD_SPARE_C, $urandom, $urandom);
    issue(srb_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(srb_pkg::CMD_POP, 32'd0, 32'd0);
  endtask

  task automatic run_random(input int unsigned goal);
    int unsigned kind;
    int unsigned k;
    int unsigned j;
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] tmp;
    logic [ID_W-1:0] ids [WIN];
    while (items_sent < goal) begin
      kind = $urandom_range(0, 199);
      if (kind < 80) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: issue(srb_pkg::CMD_INSERT, id_near_head(), $urandom);
          9, 10, 11, 12, 13, 14, 15: issue(srb_pkg::CMD_POP, $urandom, $urandom);
          default: issue(srb_pkg::CMD_MARK, id_near_head(), $urandom);
        endcase
      end else if (kind < 110) begin
        // Fill a stretch of ids at the head in shuffled order, then release it.
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(17, WIN) : $urandom_range(1, 16);
        base = sb.head_id;
        for (int unsigned i = 0; i < k; i++) ids[i] = base + i;
        for (int unsigned i = k - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = ids[i];
          ids[i] = ids[j];
          ids[j] = tmp;
        end
        for (int unsigned i = 0; i < k; i++)
          issue(($urandom_range(0, 9) == 0) ? srb_pkg::CMD_MARK : srb_pkg::CMD_INSERT,
                ids[i], $urandom);
        for (int unsigned i = 0; i <= k; i++) issue(srb_pkg::CMD_POP, $urandom, $urandom);
      end else if (kind < 126) begin
        // Drop a run of ids after the head, then the head itself, so the skip walks far.
        k = $urandom_range(2, WIN);
        base = sb.head_id;
        for (int unsigned i = 1; i < k; i++) begin
          if ($urandom_range(0, 5) == 0) issue(srb_pkg::CMD_INSERT, base + i, $urandom);
          issue(srb_pkg::CMD_MARK, base + i, $urandom);
        end
        issue(srb_pkg::CMD_MARK, base, $urandom);
        issue(srb_pkg::CMD_POP, $urandom, $urandom);
      end else if (kind < 190) begin
        case ($urandom_range(0, 5))
          0: issue($urandom_range(0, 1) ? srb_pkg::CMD_INSERT : srb_pkg::CMD_MARK,
                   sb.head_id - 1 - $urandom_range(0, 200), $urandom);
          1: issue($urandom_range(0, 1) ? srb_pkg::CMD_INSERT : srb_pkg::CMD_MARK,
                   sb.head_id + WIN + $urandom_range(0, 3000), $urandom);
          2: issue($urandom_range(0, 1) ? srb_pkg::CMD_INSERT : srb_pkg::CMD_MARK,
                   $urandom, $urandom);
          3: begin
            case ($urandom_range(0, 2))
              0: issue(CMD_SPARE_A, $urandom, $urandom);
              1: issue(CMD_SPARE_B, $urandom, $urandom);
              default: issue(CMD_SPARE_C, $urandom, $urandom);
            endcase
          end
          4: begin
            base = sb.head_id + $urandom_range(0, 3);
            issue(srb_pkg::CMD_INSERT, base, $urandom);
            issue(srb_pkg::CMD_INSERT, base, $urandom);
          end
          default: issue(srb_pkg::CMD_POP, $urandom, $urandom);
        endcase
      end else if (kind < 196) begin
        issue(srb_pkg::CMD_CLEAR, $urandom, $urandom);
      end else begin
        drain_results();
      end
    end
  endtask

  // Stop is sticky until reset, so it is exercised only at the end.
  task automatic run_stop_tail();
    issue(srb_pkg::CMD_INSERT, sb.head_id, $urandom);
    issue(srb_pkg::CMD_STOP, $urandom, $urandom);
    issue(srb_pkg::CMD_POP, 32'd0, 32'd0);
    issue(srb_pkg::CMD_INSERT, sb.head_id + 1, $urandom);
    issue(srb_pkg::CMD_MARK, sb.head_id, 32'd0);
    issue(srb_pkg::CMD_POP, 32'd0, 32'd0);
    issue(srb_pkg::CMD_CLEAR, 32'd0, 32'd0);
    issue(srb_pkg::CMD_POP, 32'd0, 32'd0);
    issue(srb_pkg::CMD_STOP, 32'd0, 32'd0);
    issue(srb_pkg::CMD_INSERT, 32'd0, 32'h0F0F_0F0F);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = srb_pkg::CMD_INSERT;
    in_ch.seq_id = '0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    items_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    rx_cycle = 0;
    rx_mode = 0;
    drains = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    drain_results();
    run_random(items_sent + 1150);
    run_stop_tail();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (2 * WIN + 20) @(posedge clk);

    $display("Ran %0d commands with %0d drain pauses: %0d delivered, %0d not ready, %0d stopped,",
             sb.commands, drains, sb.status_seen[srb_pkg::ST_DELIVERED],
             sb.status_seen[srb_pkg::ST_NOT_READY], sb.status_seen[srb_pkg::ST_STOPPED]);
    $display("%0d stale, %0d ahead, %0d duplicate, %0d accepted; %0d failures.",
             sb.status_seen[srb_pkg::ST_STALE], sb.status_seen[srb_pkg::ST_AHEAD],
             sb.status_seen[srb_pkg::ST_DUPLICATE], sb.status_seen[srb_pkg::ST_ACCEPTED],
             sb.failures);
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
